@@ design/cpfa_pkg.sv @@
// Shared types, constants and codes for the capture period frequency averager.
package cpfa_pkg;

  // Field and register widths.
  localparam int unsigned CAP_W          = 16;
  localparam int unsigned TICK_W         = 24;
  localparam int unsigned AVG_W          = 8;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned QUOT_W         = 24;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned TIMER_BITS_DEF = 16;

  // Register reset values.
  localparam logic [TICK_W-1:0] TICK_RATE_RST = 24'd1000000;
  localparam logic [AVG_W-1:0]  AVG_COUNT_RST = 8'd200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT = 2'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_DIV_AVG,
    ST_EMIT
  } cpfa_state_e;

  // Input item: one capture timestamp.
  typedef struct packed {
    logic             channel;
    logic [CAP_W-1:0] capture_time;
    logic             overflow_seen;
  } cpfa_in_t;

  // Result item: one averaged frequency.
  typedef struct packed {
    logic              out_channel;
    logic [TICK_W-1:0] average_frequency;
  } cpfa_out_t;

endpackage

@@ design/cpfa_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
module cpfa_div import cpfa_pkg::*; #(
  parameter int unsigned DIVISOR_W = TIMER_BITS_DEF + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [QUOT_W-1:0]    dividend_i,
  input  logic [DIVISOR_W-1:0] rem_init_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [QUOT_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [QUOT_W-1:0]    dvd_q, dvd_d;
  logic [DIVISOR_W:0]   trial;

  // One step: shift the next dividend bit into the remainder and try a subtract.
  assign trial = {rem_q, dvd_q[QUOT_W-1]} - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = rem_init_i;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (!trial[DIVISOR_W]) begin
        rem_d = trial[DIVISOR_W-1:0];
        dvd_d = {dvd_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIVISOR_W-2:0], dvd_q[QUOT_W-1]};
        dvd_d = {dvd_q[QUOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
  end

  // The dividend register holds the quotient once all steps are done.
  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && busy_q))
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == LAST_STEP) |=> (done_q && !busy_q))
    else $error("divider did not finish after its last step");
`endif

endmodule

@@ design/capture_period_frequency_averager.sv @@
// Two-channel capture frequency meter: sequencer, channel state and output register.
//
// Input items carry a channel, a capture timestamp and a timer overflow flag
// over a valid/ready channel. Captures on one channel alternate between start
// and end. An end capture gives a period; a nonzero period gives a frequency
// tick_rate / period, summed per channel. After avg_count frequencies the
// block sends one result item with the channel and the truncated mean.
// Both divisions run on one shared restoring divider, one quotient bit per
// cycle. A start capture, or an end capture with a zero period, leaves the
// sequencer idle. An end capture that completes no average runs one division;
// one that completes an average runs two and then loads the result into the
// output register once that register is free. in_ready_o is low from any end
// capture with a nonzero period until the sequencer is idle again.
// The result sits in an output register, so a new item is taken while a
// result waits; if the receiver stalls and a second result is ready, the
// sequencer holds in its emit state until the register frees up.
// Configuration writes (tick_rate at index 0, avg_count at index 1) are
// always taken and are meant for idle periods. Reset clears all channel
// state and loads tick_rate = 1000000 and avg_count = 200.
module capture_period_frequency_averager import cpfa_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cpfa_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cpfa_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  localparam int unsigned PER_W = TIMER_BITS + 1;
  localparam logic [PER_W-1:0] MOD_M = {1'b1, {TIMER_BITS{1'b0}}};

  cpfa_state_e state_q, state_d;

  logic [TICK_W-1:0]     tick_rate_q;
  logic [AVG_W-1:0]      avg_count_q;
  logic [1:0]            waiting_q;
  logic [TIMER_BITS-1:0] start_time_q [2];
  logic [AVG_W-1:0]      sample_cnt_q [2];
  logic [SUM_W-1:0]      freq_sum_q   [2];
  logic                  ch_q;
  logic                  out_valid_q;
  cpfa_out_t             out_data_q;

  logic                  in_accept;
  logic                  in_ch;
  logic [31:0]           cap_ext;
  logic [TIMER_BITS-1:0] cap_t;
  logic [TIMER_BITS-1:0] diff_t;
  logic [PER_W-1:0]      period;
  logic                  period_zero;
  logic                  end_capture;

  logic [SUM_W-1:0]      new_sum;
  logic [AVG_W-1:0]      new_cnt;
  logic [AVG_W-1:0]      need;
  logic                  emit_now;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [QUOT_W-1:0]     div_dividend;
  logic [PER_W-1:0]      div_rem_init;
  logic [PER_W-1:0]      div_divisor;
  logic                  out_load;

  assign in_accept   = in_valid_i && in_ready_o;
  assign in_ch       = in_data_i.channel;
  assign end_capture = waiting_q[in_ch];
  assign cfg_ready_o = 1'b1;

  // Period in timer ticks; with overflow it is one timer wrap plus the signed difference.
  assign cap_ext = 32'(in_data_i.capture_time);
  assign cap_t   = cap_ext[TIMER_BITS-1:0];
  assign diff_t  = cap_t - start_time_q[in_ch];
  always_comb begin
    if (in_data_i.overflow_seen) begin
      period = MOD_M + {1'b0, cap_t} - {1'b0, start_time_q[in_ch]};
    end else begin
      period = {1'b0, diff_t};
    end
  end
  assign period_zero = (period == '0);

  // Accumulate the new frequency and check whether an average is due.
  assign new_sum  = freq_sum_q[ch_q] + SUM_W'(div_quot);
  assign new_cnt  = sample_cnt_q[ch_q] + AVG_W'(1);
  assign need     = (avg_count_q == '0) ? AVG_W'(1) : avg_count_q;
  assign emit_now = (new_cnt != '0) && (new_cnt >= need);

  // Divider operands: the frequency division from idle, the mean otherwise.
  // The sum's top byte is below the sample count, so it seeds the remainder.
  always_comb begin
    if (state_q == ST_IDLE) begin
      div_dividend = tick_rate_q;
      div_rem_init = '0;
      div_divisor  = period;
    end else begin
      div_dividend = new_sum[QUOT_W-1:0];
      div_rem_init = PER_W'(new_sum[SUM_W-1:QUOT_W]);
      div_divisor  = PER_W'(new_cnt);
    end
  end

  cpfa_div #(
    .DIVISOR_W (PER_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .rem_init_i (div_rem_init),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && end_capture && !period_zero) begin
          state_d = ST_DIV_FREQ;
        end
      end
      ST_DIV_FREQ: begin
        if (div_done) begin
          state_d = emit_now ? ST_DIV_AVG : ST_IDLE;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_accept && end_capture && !period_zero;
      end
      ST_DIV_FREQ: begin
        div_start = div_done && emit_now;
      end
      ST_DIV_AVG: begin
      end
      ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, configuration and per-channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_rate_q <= TICK_RATE_RST;
      avg_count_q <= AVG_COUNT_RST;
      waiting_q   <= '0;
      for (int c = 0; c < 2; c++) begin
        start_time_q[c] <= '0;
        sample_cnt_q[c] <= '0;
        freq_sum_q[c]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TICK_RATE: tick_rate_q <= cfg_data_i;
          CFG_AVG_COUNT: avg_count_q <= cfg_data_i[AVG_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        if (!end_capture) begin
          start_time_q[in_ch] <= cap_t;
          waiting_q[in_ch]    <= 1'b1;
        end else begin
          waiting_q[in_ch] <= 1'b0;
        end
      end
      if (state_q == ST_DIV_FREQ && div_done) begin
        if (emit_now) begin
          freq_sum_q[ch_q]   <= '0;
          sample_cnt_q[ch_q] <= '0;
        end else begin
          freq_sum_q[ch_q]   <= new_sum;
          sample_cnt_q[ch_q] <= new_cnt;
        end
      end
    end
  end

  // Channel of the item in flight.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= in_ch;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_channel       <= ch_q;
      out_data_q.average_frequency <= div_quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_FREQ || state_q == ST_DIV_AVG))
    else $error("divider result arrived outside a division state");
  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");
  a_end_clears_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_capture) |=> !waiting_q[$past(in_ch)])
    else $error("end capture left its channel waiting");
  a_div_idle_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_IDLE) |-> !div_busy)
    else $error("divider running while sequencer not dividing");
`endif

endmodule

@@ verif/tb_capture_period_frequency_averager.sv @@
// Self-checking testbench for the two-channel capture frequency averager.
`timescale 1ns / 1ps

module tb_capture_period_frequency_averager;
  import cpfa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam int unsigned HOLD_CYCLES    = 400;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cpfa_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cpfa_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  // Shared control between the test sequence and the drivers.
  cpfa_in_t    capture_q [$];
  cpfa_out_t   expected_averages [$];
  logic        steady = 1'b0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int          errors = 0;

  // Start/end phase of each channel as seen by the stimulus generator.
  logic             plan_waiting [2] = '{1'b0, 1'b0};
  logic [CAP_W-1:0] plan_start [2] = '{'0, '0};

  // Predicted meter state and register copies.
  logic              meter_waiting [2] = '{1'b0, 1'b0};
  logic [CAP_W-1:0]  meter_start [2] = '{'0, '0};
  logic [AVG_W-1:0]  meter_count [2] = '{'0, '0};
  logic [63:0]       meter_sum [2] = '{'0, '0};
  logic [TICK_W-1:0] tick_reg = TICK_RATE_RST;
  logic [AVG_W-1:0]  avg_reg = AVG_COUNT_RST;

  capture_period_frequency_averager u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the predicted meter by one accepted capture item.
  function automatic void record_capture(input cpfa_in_t item);
    logic             ch;
    logic [16:0]      period;
    logic [AVG_W-1:0] need;
    cpfa_out_t        avg_item;
    ch = item.channel;
    if (!meter_waiting[ch]) begin
      meter_start[ch] = item.capture_time;
      meter_waiting[ch] = 1'b1;
      return;
    end
    meter_waiting[ch] = 1'b0;
    if (item.overflow_seen) begin
      period = 17'h10000 + item.capture_time - meter_start[ch];
    end else begin
      period = {1'b0, item.capture_time - meter_start[ch]};
    end
    // A zero period is dropped without counting as a sample.
    if (period == 0) return;
    meter_sum[ch] = meter_sum[ch] + tick_reg / period;
    meter_count[ch] = meter_count[ch] + 8'd1;
    need = (avg_reg == 0) ? 8'd1 : avg_reg;
    if (meter_count[ch] != 0 && meter_count[ch] >= need) begin
      avg_item.out_channel = ch;
      avg_item.average_frequency = TICK_W'(meter_sum[ch] / meter_count[ch]);
      expected_averages.push_back(avg_item);
      meter_sum[ch] = '0;
      meter_count[ch] = '0;
    end
  endfunction

  // Compare one accepted result with the oldest expected average.
  function automatic void check_average(input cpfa_out_t got);
    cpfa_out_t want;
    if (expected_averages.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got channel %0d average %0d",
               $time, got.out_channel, got.average_frequency);
      return;
    end
    want = expected_averages.pop_front();
    if (got.out_channel !== want.out_channel) begin
      errors++;
      $display("%0t: out_channel expected %0d, got %0d",
               $time, want.out_channel, got.out_channel);
    end
    if (got.average_frequency !== want.average_frequency) begin
      errors++;
      $display("%0t: average_frequency expected %0d, got %0d",
               $time, want.average_frequency, got.average_frequency);
    end
  endfunction

  // Monitor: check results, then predict from accepted items and register writes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_average(out_data);
      if (in_valid && in_ready) record_capture(in_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TICK_RATE) begin
          tick_reg = cfg_data;
        end else if (cfg_index == CFG_AVG_COUNT) begin
          avg_reg = cfg_data[AVG_W-1:0];
        end
      end
    end
  end

  // Input driver: offers queued capture items with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) void'(capture_q.pop_front());
      if (capture_q.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
        in_valid <= 1'b1;
        in_data <= capture_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Watchdog: ends the run when no handshake completes for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("capture_period_frequency_averager: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Queue one capture item, keeping at most one waiting behind the one on the bus.
  task automatic send_capture(input cpfa_in_t item);
    if (!plan_waiting[item.channel]) begin
      plan_start[item.channel] = item.capture_time;
      plan_waiting[item.channel] = 1'b1;
    end else begin
      plan_waiting[item.channel] = 1'b0;
    end
    capture_q.push_back(item);
    while (capture_q.size() > 1) @(posedge clk);
  endtask

  // Send a start/end pair; a dangling start is closed first with a zero period.
  task automatic send_pair(input logic ch, input logic [CAP_W-1:0] start_t,
                           input logic [CAP_W-1:0] end_t, input logic ovf);
    if (plan_waiting[ch]) send_capture('{ch, plan_start[ch], 1'b0});
    send_capture('{ch, start_t, ~ovf});
    send_capture('{ch, end_t, ovf});
  endtask

  // Random captures: mostly proper pairs with shaped periods, some noise.
  task automatic send_random_captures(input int unsigned count, input int unsigned ch0_pct);
    cpfa_in_t    item;
    logic        ch;
    int unsigned roll;
    repeat (count) begin
      ch = ($urandom_range(99) >= ch0_pct);
      item.channel = ch;
      item.capture_time = CAP_W'($urandom);
      item.overflow_seen = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll >= 10 && plan_waiting[ch]) begin
        if (roll < 16) begin
          item.capture_time = plan_start[ch];
          item.overflow_seen = 1'b0;
        end else if (roll < 40) begin
          item.capture_time = plan_start[ch] + CAP_W'($urandom_range(64, 1));
          item.overflow_seen = 1'b0;
        end else if (roll < 60) begin
          item.overflow_seen = 1'b1;
        end else begin
          item.overflow_seen = 1'b0;
        end
      end
      send_capture(item);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every item is taken and every average has come back, then settle.
  task automatic wait_idle();
    while (capture_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register values after reset, mostly on channel 0 so one average completes.
  task automatic test_default_registers();
    send_random_captures(500, 90);
  endtask

  // Period and frequency extremes with one average per completed period.
  task automatic test_directed_extremes();
    wait_idle();
    write_register(CFG_TICK_RATE, 24'hFFFFFF);
    write_register(CFG_AVG_COUNT, 24'h000001);
    send_pair(1'b0, 16'h0000, 16'hFFFF, 1'b0);
    send_pair(1'b1, 16'hFFFF, 16'h0000, 1'b1);
    send_pair(1'b0, 16'hFFFF, 16'h0000, 1'b0);
    send_pair(1'b1, 16'h8000, 16'h0001, 1'b1);
    send_pair(1'b0, 16'h0000, 16'hFFFF, 1'b1);
    send_pair(1'b1, 16'h5A5A, 16'h5A5A, 1'b1);
    send_pair(1'b0, 16'h1234, 16'h1234, 1'b0);
    send_pair(1'b1, 16'hAAAA, 16'h5555, 1'b0);
  endtask

  // Zero tick rate, zero average count, and a write to an unused index.
  task automatic test_zero_settings();
    wait_idle();
    write_register(CFG_TICK_RATE, 24'h000000);
    write_register(CFG_AVG_COUNT, 24'hABCD00);
    write_register(CFG_SPARE, 24'h5A5A5A);
    send_pair(1'b0, 16'h0100, 16'h0101, 1'b0);
    send_pair(1'b1, 16'h7777, 16'h7777, 1'b0);
    send_pair(1'b1, 16'hF000, 16'h0010, 1'b1);
  endtask

  // Average count lowered below the samples already collected.
  task automatic test_lowered_average();
    wait_idle();
    write_register(CFG_TICK_RATE, TICK_W'($urandom_range(24'hFFFFFF, 1)));
    write_register(CFG_AVG_COUNT, 24'h000004);
    repeat (3) send_pair(1'b0, CAP_W'($urandom), CAP_W'($urandom), 1'b1);
    wait_idle();
    write_register(CFG_AVG_COUNT, {16'($urandom), 8'd2});
    send_pair(1'b0, CAP_W'($urandom), CAP_W'($urandom), 1'b1);
  endtask

  // Random traffic under several register settings.
  task automatic test_random_sweep();
    logic [TICK_W-1:0] rates [5];
    logic [AVG_W-1:0]  sizes [5];
    rates = '{TICK_W'($urandom_range(24'hFFFFFF, 1)), 24'd1,
              TICK_W'($urandom_range(24'hFFFFFF, 1)), 24'hFFFFFF,
              TICK_W'($urandom_range(24'hFFFFFF, 1))};
    sizes = '{8'd1, 8'd2, 8'd7, 8'd255, AVG_W'($urandom_range(16, 1))};
    for (int k = 0; k < 5; k++) begin
      wait_idle();
      write_register(CFG_TICK_RATE, rates[k]);
      write_register(CFG_AVG_COUNT, {16'($urandom), sizes[k]});
      steady <= (k == 2);
      send_random_captures(220, 50);
    end
    wait_idle();
    steady <= 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering short periods.
  task automatic test_output_backpressure();
    logic [CAP_W-1:0] s;
    wait_idle();
    write_register(CFG_TICK_RATE, TICK_W'($urandom_range(24'hFFFFFF, 1)));
    write_register(CFG_AVG_COUNT, 24'h000001);
    steady <= 1'b1;
    hold_trigger <= ~hold_trigger;
    repeat (40) begin
      s = CAP_W'($urandom);
      send_pair(1'($urandom_range(1)), s, s + CAP_W'($urandom_range(200, 1)), 1'b0);
    end
    wait_idle();
    steady <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_directed_extremes();
    test_zero_settings();
    test_lowered_average();
    test_random_sweep();
    test_output_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("capture_period_frequency_averager: match");
    end else begin
      $display("capture_period_frequency_averager: mismatch");
    end
    $finish;
  end

endmodule
